/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/fve_pkg.sv */
// Package for the flow-to-velocity estimator: widths, register codes, control types.
`default_nettype none
package fve_pkg;

    localparam int FRAMES_PER_REPORT_DEF = 2;

    localparam int S_DATA_W   = 136;
    localparam int M_DATA_W   = 104;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int DVD_W = 44;   // dividend magnitude width
    localparam int DVS_W = 36;   // divisor width (focal * interval)

    localparam logic [27:0] FLOW_SCALE = 28'd256000000;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_SEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_FILT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST   = 3'd6;

    localparam logic [18:0] RST_GYRO_THR = 19'd0;
    localparam logic [15:0] RST_WEIGHT   = 16'd19661;
    localparam logic [15:0] RST_FOCAL    = 16'd8000;
    localparam logic [15:0] RST_MAX_DIST = 16'd5000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_VEL,
        ST_LP_KEEP,
        ST_LP_NEW,
        ST_UPDATE,
        ST_ROUTE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_DIV_AX,
        OP_TAKE_AX,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_VEL,
        OP_LP_KEEP,
        OP_LP_NEW,
        OP_UPDATE,
        OP_DIV_MEAN,
        OP_TAKE_MEAN,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic report;
        logic need_mean;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* sv/fve_div.sv */
// Bit-serial restoring divider, unsigned, one quotient bit per cycle.
`default_nettype none
module fve_div
    import fve_pkg::*;
#(
    parameter int DIVIDEND_W = DVD_W,
    parameter int DIVISOR_W  = DVS_W
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic      [DIVIDEND_W-1:0] quotient,
    output logic                       done
);
    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W+1:0] diff;
    logic                 borrow;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign borrow  = diff[DIVISOR_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ~borrow};
            rem_reg <= borrow ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule
`default_nettype wire

/* sv/fve_datapath.sv */
// Datapath: config registers, arithmetic steps, running state and output register.
`default_nettype none
module fve_datapath
    import fve_pkg::*;
#(
    parameter int FRAMES_PER_REPORT = FRAMES_PER_REPORT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,
    output logic      [0:0]            m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int VW = $clog2(FRAMES_PER_REPORT + 1);
    localparam int PW = (FRAMES_PER_REPORT > 1) ? $clog2(FRAMES_PER_REPORT) : 1;

    // configuration
    logic        gyro_en_reg, lp_sel_reg, use_filt_reg;
    logic [18:0] gyro_thr_reg;
    logic [15:0] weight_reg, focal_reg, max_dist_reg;

    // latched frame
    logic signed [15:0] fx_reg, fy_reg;
    logic        [7:0]  qual_reg;
    logic signed [19:0] rsx_reg, rsy_reg;
    logic        [15:0] dfilt_reg, draw_reg;
    logic        [19:0] tus_reg;

    // working registers
    logic signed [44:0] num_x_reg, num_y_reg;
    logic [DVS_W-1:0]   den_reg;
    logic               sgn_x_reg, sgn_y_reg;
    logic signed [32:0] ax_reg, ay_reg;
    logic signed [33:0] ph_x_reg, ph_y_reg;
    logic signed [49:0] p_x_reg, p_y_reg;
    logic signed [23:0] nv_x_reg, nv_y_reg;
    logic signed [42:0] acc_x_reg, acc_y_reg;
    logic signed [23:0] mean_x_reg, mean_y_reg;

    // running state
    logic signed [24:0] vsum_x_reg, vsum_y_reg;
    logic signed [23:0] lp_x_reg, lp_y_reg;
    logic signed [16:0] pix_x_reg, pix_y_reg;
    logic [VW-1:0]      vcnt_reg;
    logic [PW-1:0]      phase_reg;
    logic               report_reg;

    // output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_en_reg  <= 1'b1;
            gyro_thr_reg <= RST_GYRO_THR;
            weight_reg   <= RST_WEIGHT;
            lp_sel_reg   <= 1'b0;
            use_filt_reg <= 1'b1;
            focal_reg    <= RST_FOCAL;
            max_dist_reg <= RST_MAX_DIST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GYRO_EN:  gyro_en_reg  <= cfg_data[0];
                CFG_GYRO_THR: gyro_thr_reg <= cfg_data;
                CFG_WEIGHT:   weight_reg   <= cfg_data[15:0];
                CFG_LP_SEL:   lp_sel_reg   <= cfg_data[0];
                CFG_USE_FILT: use_filt_reg <= cfg_data[0];
                CFG_FOCAL:    focal_reg    <= cfg_data[15:0];
                CFG_MAX_DIST: max_dist_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // frame qualification
    logic dvalid, feed;
    assign dvalid = (dfilt_reg != 16'd0) && (dfilt_reg <= max_dist_reg);
    assign feed   = dvalid && (qual_reg != 8'd0);

    logic [15:0] focal_eff;
    logic [19:0] tus_eff;
    assign focal_eff = (focal_reg == 16'd0) ? 16'd1 : focal_reg;
    assign tus_eff   = (tus_reg == 20'd0) ? 20'd1 : tus_reg;

    // divider operands
    logic [DVD_W-1:0] dvd_x, dvd_y, q_x, q_y;
    logic [DVS_W-1:0] dvs;
    logic             div_start, div_done_x, div_done_y;
    logic [44:0]      num_x_mag, num_y_mag;
    logic [24:0]      vs_x_mag, vs_y_mag;

    assign num_x_mag = num_x_reg[44] ? 45'(-num_x_reg) : 45'(num_x_reg);
    assign num_y_mag = num_y_reg[44] ? 45'(-num_y_reg) : 45'(num_y_reg);
    assign vs_x_mag  = vsum_x_reg[24] ? 25'(-vsum_x_reg) : 25'(vsum_x_reg);
    assign vs_y_mag  = vsum_y_reg[24] ? 25'(-vsum_y_reg) : 25'(vsum_y_reg);

    always_comb begin
        div_start = 1'b0;
        dvd_x     = num_x_mag[DVD_W-1:0];
        dvd_y     = num_y_mag[DVD_W-1:0];
        dvs       = den_reg;
        case (cmd.op)
            OP_DIV_AX: div_start = 1'b1;
            OP_DIV_MEAN: begin
                div_start = 1'b1;
                dvd_x     = {{(DVD_W-25){1'b0}}, vs_x_mag};
                dvd_y     = {{(DVD_W-25){1'b0}}, vs_y_mag};
                dvs       = {{(DVS_W-VW){1'b0}}, vcnt_reg};
            end
            default: ;
        endcase
    end

    fve_div #(.DIVIDEND_W(DVD_W), .DIVISOR_W(DVS_W)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(dvd_x), .divisor(dvs), .quotient(q_x), .done(div_done_x)
    );
    fve_div #(.DIVIDEND_W(DVD_W), .DIVISOR_W(DVS_W)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(dvd_y), .divisor(dvs), .quotient(q_y), .done(div_done_y)
    );

    // signed quotients
    logic signed [44:0] qs_x, qs_y;
    assign qs_x = sgn_x_reg ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
    assign qs_y = sgn_y_reg ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});

    function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
        if (v > 45'sd2147483647)       sat32 = 32'sh7FFFFFFF;
        else if (v < -45'sd2147483648) sat32 = 32'sh80000000;
        else                           sat32 = v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24_45(input logic signed [44:0] v);
        if (v > 45'sd8388607)       sat24_45 = 24'sh7FFFFF;
        else if (v < -45'sd8388608) sat24_45 = 24'sh800000;
        else                        sat24_45 = v[23:0];
    endfunction

    function automatic logic signed [23:0] sat24_51(input logic signed [50:0] v);
        if (v > 51'sd8388607)       sat24_51 = 24'sh7FFFFF;
        else if (v < -51'sd8388608) sat24_51 = 24'sh800000;
        else                        sat24_51 = v[23:0];
    endfunction

    function automatic logic signed [23:0] sat24_43(input logic signed [42:0] v);
        if (v > 43'sd8388607)       sat24_43 = 24'sh7FFFFF;
        else if (v < -43'sd8388608) sat24_43 = 24'sh800000;
        else                        sat24_43 = v[23:0];
    endfunction

    // gyro compensation: x gets rate_sensor_x, y gets rate_sensor_y
    logic [19:0] rsx_mag, rsy_mag;
    logic        comp_x, comp_y;
    assign rsx_mag = rsx_reg[19] ? 20'(-rsx_reg) : 20'(rsx_reg);
    assign rsy_mag = rsy_reg[19] ? 20'(-rsy_reg) : 20'(rsy_reg);
    assign comp_x  = gyro_en_reg && (rsx_mag > {1'b0, gyro_thr_reg});
    assign comp_y  = gyro_en_reg && (rsy_mag > {1'b0, gyro_thr_reg});

    logic signed [32:0] ax_next, ay_next;
    assign ax_next = 33'(sat32(qs_x)) + (comp_x ? 33'(rsx_reg) : 33'sd0);
    assign ay_next = 33'(sat32(qs_y)) + (comp_y ? 33'(rsy_reg) : 33'sd0);

    // velocity: -(a * d) / 4096, toward zero
    logic signed [50:0] nn_x, nn_y, nt_x, nt_y;
    assign nn_x = -$signed({p_x_reg[49], p_x_reg});
    assign nn_y = -$signed({p_y_reg[49], p_y_reg});
    assign nt_x = (nn_x + (nn_x[50] ? 51'sd4095 : 51'sd0)) >>> 12;
    assign nt_y = (nn_y + (nn_y[50] ? 51'sd4095 : 51'sd0)) >>> 12;

    // lowpass
    logic [16:0]        keep;
    logic signed [42:0] lt_x, lt_y;
    assign keep = 17'h10000 - {1'b0, weight_reg};
    assign lt_x = (acc_x_reg + (acc_x_reg[42] ? 43'sd65535 : 43'sd0)) >>> 16;
    assign lt_y = (acc_y_reg + (acc_y_reg[42] ? 43'sd65535 : 43'sd0)) >>> 16;

    // saturating sums
    logic signed [25:0] vs_x_next, vs_y_next;
    logic signed [17:0] px_next, py_next;
    assign vs_x_next = {vsum_x_reg[24], vsum_x_reg} + 26'(nv_x_reg);
    assign vs_y_next = {vsum_y_reg[24], vsum_y_reg} + 26'(nv_y_reg);
    assign px_next   = {pix_x_reg[16], pix_x_reg} + 18'(fx_reg);
    assign py_next   = {pix_y_reg[16], pix_y_reg} + 18'(fy_reg);

    function automatic logic signed [24:0] sat25(input logic signed [25:0] v);
        if (v[25] != v[24]) sat25 = v[25] ? 25'sh1000000 : 25'shFFFFFF;
        else                sat25 = v[24:0];
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [17:0] v);
        if (v[17] != v[16]) sat17 = v[17] ? 17'sh10000 : 17'shFFFF;
        else                sat17 = v[16:0];
    endfunction

    // pixel sums in tenths of a pixel
    function automatic logic signed [12:0] tenths(input logic signed [16:0] v);
        logic signed [21:0] t;
        logic signed [21:0] s;
        t = 22'(v) * 22'sd10;
        s = (t + (t[21] ? 22'sd255 : 22'sd0)) >>> 8;
        if (s > 22'sd4095)       tenths = 13'sh0FFF;
        else if (s < -22'sd4096) tenths = 13'sh1000;
        else                     tenths = s[12:0];
    endfunction

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                fx_reg    <= s_tdata[15:0];
                fy_reg    <= s_tdata[31:16];
                qual_reg  <= s_tdata[39:32];
                rsx_reg   <= s_tdata[59:40];
                rsy_reg   <= s_tdata[79:60];
                dfilt_reg <= s_tdata[95:80];
                draw_reg  <= s_tdata[111:96];
                tus_reg   <= s_tdata[131:112];
            end
            OP_PREP: begin
                num_x_reg <= fx_reg * $signed({1'b0, FLOW_SCALE});
                num_y_reg <= fy_reg * $signed({1'b0, FLOW_SCALE});
                den_reg   <= focal_eff * tus_eff;
            end
            OP_DIV_AX: begin
                sgn_x_reg <= num_x_reg[44];
                sgn_y_reg <= num_y_reg[44];
            end
            OP_TAKE_AX: begin
                ax_reg <= ax_next;
                ay_reg <= ay_next;
            end
            OP_MUL_HI: begin
                ph_x_reg <= $signed(ax_reg[32:16]) * $signed({1'b0, dfilt_reg});
                ph_y_reg <= $signed(ay_reg[32:16]) * $signed({1'b0, dfilt_reg});
            end
            OP_MUL_LO: begin
                p_x_reg <= (50'(ph_x_reg) <<< 16) + 50'(ax_reg[15:0] * dfilt_reg);
                p_y_reg <= (50'(ph_y_reg) <<< 16) + 50'(ay_reg[15:0] * dfilt_reg);
            end
            OP_VEL: begin
                nv_x_reg <= sat24_51(nt_x);
                nv_y_reg <= sat24_51(nt_y);
            end
            OP_LP_KEEP: begin
                acc_x_reg <= 43'($signed({1'b0, keep}) * lp_x_reg);
                acc_y_reg <= 43'($signed({1'b0, keep}) * lp_y_reg);
            end
            OP_LP_NEW: begin
                if (feed) begin
                    acc_x_reg <= acc_x_reg + 43'($signed({1'b0, weight_reg}) * nv_x_reg);
                    acc_y_reg <= acc_y_reg + 43'($signed({1'b0, weight_reg}) * nv_y_reg);
                end
            end
            OP_DIV_MEAN: begin
                sgn_x_reg <= vsum_x_reg[24];
                sgn_y_reg <= vsum_y_reg[24];
            end
            OP_TAKE_MEAN: begin
                mean_x_reg <= sat24_45(qs_x);
                mean_y_reg <= sat24_45(qs_y);
            end
            default: ;
        endcase
    end

    // running state and output register
    logic signed [23:0] vx_out, vy_out;
    logic               any_valid;
    assign any_valid = (vcnt_reg != '0);
    assign vx_out = !any_valid ? 24'sd0 : (lp_sel_reg ? lp_x_reg : mean_x_reg);
    assign vy_out = !any_valid ? 24'sd0 : (lp_sel_reg ? lp_y_reg : mean_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vsum_x_reg   <= '0;
            vsum_y_reg   <= '0;
            lp_x_reg     <= '0;
            lp_y_reg     <= '0;
            pix_x_reg    <= '0;
            pix_y_reg    <= '0;
            vcnt_reg     <= '0;
            phase_reg    <= '0;
            report_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_EMIT)             m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            case (cmd.op)
                OP_UPDATE: begin
                    lp_x_reg  <= sat24_43(lt_x);
                    lp_y_reg  <= sat24_43(lt_y);
                    pix_x_reg <= sat17(px_next);
                    pix_y_reg <= sat17(py_next);
                    if (feed) begin
                        vsum_x_reg <= sat25(vs_x_next);
                        vsum_y_reg <= sat25(vs_y_next);
                        if (vcnt_reg < VW'(FRAMES_PER_REPORT)) vcnt_reg <= vcnt_reg + 1'b1;
                    end
                    if (phase_reg == PW'(FRAMES_PER_REPORT - 1)) begin
                        phase_reg  <= '0;
                        report_reg <= 1'b1;
                    end else begin
                        phase_reg  <= phase_reg + 1'b1;
                        report_reg <= 1'b0;
                    end
                end
                OP_EMIT: begin
                    m_tuser_reg  <= any_valid;
                    m_tdata_reg  <= {6'd0,
                                     use_filt_reg ? (dvalid ? dfilt_reg : 16'd0) : draw_reg,
                                     any_valid ? qual_reg : 8'd0,
                                     vy_out, vx_out,
                                     tenths(pix_y_reg), tenths(pix_x_reg)};
                    vsum_x_reg   <= '0;
                    vsum_y_reg   <= '0;
                    pix_x_reg    <= '0;
                    pix_y_reg    <= '0;
                    vcnt_reg     <= '0;
                    report_reg   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign status.div_done  = div_done_x && div_done_y;
    assign status.report    = report_reg;
    assign status.need_mean = report_reg && any_valid && !lp_sel_reg;
    assign status.out_free  = !m_tvalid_reg || m_tready;
endmodule
`default_nettype wire

/* sv/fve_ctrl.sv */
// Controller: sequences the datapath steps for one frame.
`default_nettype none
module fve_ctrl
    import fve_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.op     = OP_PREP;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.op     = OP_DIV_AX;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_TAKE_AX;
                    state_next = ST_MUL_HI;
                end
            end
            ST_MUL_HI: begin
                cmd.op     = OP_MUL_HI;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.op     = OP_MUL_LO;
                state_next = ST_VEL;
            end
            ST_VEL: begin
                cmd.op     = OP_VEL;
                state_next = ST_LP_KEEP;
            end
            ST_LP_KEEP: begin
                cmd.op     = OP_LP_KEEP;
                state_next = ST_LP_NEW;
            end
            ST_LP_NEW: begin
                cmd.op     = OP_LP_NEW;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.op     = OP_UPDATE;
                state_next = ST_ROUTE;
            end
            ST_ROUTE: begin
                if (!status.report)        state_next = ST_IDLE;
                else if (status.need_mean) state_next = ST_MEAN_GO;
                else                       state_next = ST_EMIT;
            end
            ST_MEAN_GO: begin
                cmd.op     = OP_DIV_MEAN;
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_TAKE_MEAN;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* sv/flow_to_velocity_estimator_top.sv */
// Top level of the flow-to-velocity estimator.
// One input transaction per camera frame; one result transaction every
// FRAMES_PER_REPORT frames. A frame is worked through in full before the next
// frame can be accepted. Each frame runs the pair of bit-serial dividers (44
// quotient bits, one per cycle) once for the angular flow of both axes; a
// report frame that averages the velocity sums runs them once more for the
// mean, while a report with the lowpass velocity or with no valid frame skips
// it. A report frame can also wait for m_tready on the previous result. A
// finished result sits in the output register while the next
// frame is already being worked on. Configuration writes are always accepted
// (cfg_ready is tied high) and must only be issued while the block is idle;
// unknown indexes are ignored.
`default_nettype none
module flow_to_velocity_estimator_top
    import fve_pkg::*;
#(
    parameter int FRAMES_PER_REPORT = FRAMES_PER_REPORT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input frame stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // flow_x[15:0], flow_y[31:16], quality[39:32], rate_sensor_x[59:40],
    // rate_sensor_y[79:60], distance_filtered[95:80], distance_raw[111:96],
    // frame_interval_us[131:112], zero pad[135:132]
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // flow_sum_x_tenths[12:0], flow_sum_y_tenths[25:13], velocity_x[49:26],
    // velocity_y[73:50], quality_out[81:74], reported_dist[97:82], zero pad[103:98]
    output logic      [M_DATA_W-1:0]   m_tdata,
    // velocity_valid[0]
    output logic      [0:0]            m_tuser,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    cmd_t    cmd;
    status_t status;

    // sequencer: one step of the frame computation per state
    fve_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .status(status), .cmd(cmd)
    );

    // arithmetic, running sums, lowpass and output register
    fve_datapath #(.FRAMES_PER_REPORT(FRAMES_PER_REPORT)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .status(status),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );
endmodule
`default_nettype wire

/* sv/fve_checker.sv */
// Port-level checker for the flow-to-velocity estimator, with its bind.
`default_nettype none
`include "assert_macros.svh"
module fve_checker
    import fve_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_DATA_W-1:0]   m_tdata,
    input wire logic [0:0]            m_tuser
);
    // a stalled result stays offered
    `ASSERT_RST(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")
    // reset clears the result register
    `ASSERT_ALWAYS(a_rst_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    // no valid frame in the period means zero velocity and quality
    `ASSERT_RST(a_zero_vel, aclk, aresetn, (m_tvalid && !m_tuser[0]) |-> (m_tdata[81:26] == '0), "velocity not zeroed")
    // one frame at a time: busy right after a frame is taken
    `ASSERT_RST(a_busy, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "frame accepted while busy")
endmodule

bind flow_to_velocity_estimator_top fve_checker u_fve_checker (.*);
`default_nettype wire

/* tb/flow_to_velocity_estimator_top_tb.sv */
// Self-checking testbench for the flow-to-velocity estimator top level.
`timescale 1ns / 100ps
`default_nettype none
module flow_to_velocity_estimator_top_tb;
    import fve_pkg::*;

    localparam int FPR = 2;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #1 aclk = ~aclk;

    flow_to_velocity_estimator_top #(.FRAMES_PER_REPORT(FPR)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [19:0] interval;
        logic [15:0] dist_raw;
        logic [15:0] dist_filt;
        logic signed [19:0] rate_y;
        logic signed [19:0] rate_x;
        logic [7:0] quality;
        logic signed [15:0] flow_y;
        logic signed [15:0] flow_x;
    } frame_t;

    typedef struct packed {
        logic vvalid;
        logic [15:0] gdist;
        logic [7:0] qual;
        logic signed [23:0] vel_y;
        logic signed [23:0] vel_x;
        logic signed [12:0] tenths_y;
        logic signed [12:0] tenths_x;
    } report_t;

    // Shadow copy of configuration
    logic        sh_gyro_en;
    logic [18:0] sh_gyro_thr;
    logic [15:0] sh_weight;
    logic        sh_lp_sel;
    logic        sh_use_filt;
    logic [15:0] sh_focal;
    logic [15:0] sh_max_dist;

    // Shadow copy of estimator state
    longint vsum_x, vsum_y, lp_x, lp_y, psum_x, psum_y;
    int     nvalid, phase;

    report_t reports_due[$];
    int errors = 0;
    int n_reports = 0;
    int n_frames = 0;
    bit hold_off = 1'b0;

    function automatic longint clamp(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -(longint'(1) <<< (w - 1));
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint lowpass_next(longint lp, longint nv, bit feed);
        longint w, num;
        w = longint'(sh_weight);
        num = (65536 - w) * lp + (feed ? w * nv : 0);
        return clamp(num / 65536, 24);
    endfunction

    // Advances the shadow state by one frame; returns 1 when a report is due.
    function automatic bit estimate_frame(frame_t f, output report_t r);
        longint fl, tu, dv, ax, ay, rx, ry, nvx, nvy, df, mag_x, mag_y;
        bit dvalid;
        fl = (sh_focal == 0) ? 1 : longint'(sh_focal);
        tu = (f.interval == 0) ? 1 : longint'(f.interval);
        dv = fl * tu;
        ax = clamp(longint'(f.flow_x) * 256000000 / dv, 32);
        ay = clamp(longint'(f.flow_y) * 256000000 / dv, 32);
        rx = longint'(f.rate_y);
        ry = -longint'(f.rate_x);
        mag_x = rx < 0 ? -rx : rx;
        mag_y = ry < 0 ? -ry : ry;
        if (sh_gyro_en) begin
            if (mag_y > longint'(sh_gyro_thr)) ax -= ry;
            if (mag_x > longint'(sh_gyro_thr)) ay += rx;
        end
        df = longint'(f.dist_filt);
        dvalid = (df != 0) && (df <= longint'(sh_max_dist));
        if (!dvalid) df = 0;
        if (dvalid && f.quality > 0) begin
            nvx = clamp(-(ax * df) / 4096, 24);
            nvy = clamp(-(ay * df) / 4096, 24);
            vsum_x = clamp(vsum_x + nvx, 25);
            vsum_y = clamp(vsum_y + nvy, 25);
            if (nvalid < FPR) nvalid++;
            lp_x = lowpass_next(lp_x, nvx, 1'b1);
            lp_y = lowpass_next(lp_y, nvy, 1'b1);
        end else begin
            lp_x = lowpass_next(lp_x, 0, 1'b0);
            lp_y = lowpass_next(lp_y, 0, 1'b0);
        end
        psum_x = clamp(psum_x + longint'(f.flow_x), 17);
        psum_y = clamp(psum_y + longint'(f.flow_y), 17);
        phase++;
        r = '0;
        if (phase < FPR) return 1'b0;
        phase = 0;
        r.tenths_x = 13'(clamp(psum_x * 10 / 256, 13));
        r.tenths_y = 13'(clamp(psum_y * 10 / 256, 13));
        if (nvalid > 0) begin
            if (sh_lp_sel) begin
                r.vel_x = 24'(lp_x);
                r.vel_y = 24'(lp_y);
            end else begin
                r.vel_x = 24'(clamp(vsum_x / nvalid, 24));
                r.vel_y = 24'(clamp(vsum_y / nvalid, 24));
            end
            r.qual = f.quality;
            r.vvalid = 1'b1;
        end
        r.gdist = sh_use_filt ? df[15:0] : f.dist_raw;
        vsum_x = 0; vsum_y = 0; psum_x = 0; psum_y = 0; nvalid = 0;
        return 1'b1;
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GYRO_EN:  sh_gyro_en  = val[0];
            CFG_GYRO_THR: sh_gyro_thr = val[18:0];
            CFG_WEIGHT:   sh_weight   = val[15:0];
            CFG_LP_SEL:   sh_lp_sel   = val[0];
            CFG_USE_FILT: sh_use_filt = val[0];
            CFG_FOCAL:    sh_focal    = val[15:0];
            CFG_MAX_DIST: sh_max_dist = val[15:0];
            default: ;
        endcase
    endtask

    // Short gaps mostly, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // Offers one frame, predicts it once it is taken
    task automatic send_frame(frame_t f, bit known, report_t exp_known);
        report_t r;
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            wait_cycles(g);
        end
        s_tdata  <= S_DATA_W'(f);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        n_frames++;
        if (estimate_frame(f, r)) begin
            if (known && r != exp_known) begin
                $display("%0t table row disagrees with predictor: table %h predictor %h",
                         $time, exp_known, r);
                errors++;
            end
            reports_due.push_back(r);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        // a frame that produces no report may still be in flight
        wait_cycles(150);
    endtask

    function automatic frame_t random_frame();
        frame_t f;
        int p;
        f.flow_x  = 16'($urandom());
        f.flow_y  = 16'($urandom());
        f.rate_x  = 20'($urandom());
        f.rate_y  = 20'($urandom());
        f.dist_raw = 16'($urandom());
        p = $urandom_range(0, 9);
        f.quality = (p == 0) ? 8'd0 : 8'($urandom());
        p = $urandom_range(0, 9);
        if (p == 0) f.dist_filt = 0;
        else if (p == 1) f.dist_filt = 16'($urandom());
        else f.dist_filt = 16'($urandom_range(1, (sh_max_dist == 0) ? 1 : sh_max_dist));
        p = $urandom_range(0, 9);
        if (p == 0) f.interval = 20'($urandom());
        else if (p == 1) f.interval = 20'($urandom_range(0, 3));
        else f.interval = 20'($urandom_range(5000, 40000));
        if ($urandom_range(0, 3) != 0) begin
            // realistic sized flow and rates so sums do not always clip
            f.flow_x = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            f.flow_y = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            f.rate_x = $signed(20'($urandom_range(0, 8000))) - 20'sd4000;
            f.rate_y = $signed(20'($urandom_range(0, 8000))) - 20'sd4000;
        end
        return f;
    endfunction

    // Result side: random ready, one long hold-off on request
    initial begin
        int g;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (800) @(posedge aclk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                wait_cycles(g);
            end
            m_tready <= 1'b1;
        end
    end

    // Result checker: compares each report transaction with the oldest prediction
    always @(posedge aclk) begin
        report_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tdata[97:0]};
            if (reports_due.size() == 0) begin
                $display("%0t unexpected report: actual %h", $time, got);
                errors++;
            end else begin
                want = reports_due.pop_front();
                n_reports++;
                if (got.tenths_x !== want.tenths_x)
                    $display("%0t flow_sum_x_tenths expected %0d actual %0d",
                             $time, want.tenths_x, got.tenths_x);
                if (got.tenths_y !== want.tenths_y)
                    $display("%0t flow_sum_y_tenths expected %0d actual %0d",
                             $time, want.tenths_y, got.tenths_y);
                if (got.vel_x !== want.vel_x)
                    $display("%0t velocity_x expected %0d actual %0d",
                             $time, want.vel_x, got.vel_x);
                if (got.vel_y !== want.vel_y)
                    $display("%0t velocity_y expected %0d actual %0d",
                             $time, want.vel_y, got.vel_y);
                if (got.qual !== want.qual)
                    $display("%0t quality_out expected %0d actual %0d",
                             $time, want.qual, got.qual);
                if (got.gdist !== want.gdist)
                    $display("%0t reported_dist expected %0d actual %0d",
                             $time, want.gdist, got.gdist);
                if (got.vvalid !== want.vvalid)
                    $display("%0t velocity_valid expected %0d actual %0d",
                             $time, want.vvalid, got.vvalid);
                if (got !== want) errors++;
            end
        end
    end

    // Directed table; a row with a known report carries it, else the predictor decides
    typedef struct {
        frame_t  f;
        bit      known;
        report_t r;
    } row_t;

    initial begin
        row_t rows[$];
        row_t row;
        frame_t f;
        report_t none_r;
        int i;

        sh_gyro_en = 1'b1; sh_gyro_thr = RST_GYRO_THR; sh_weight = RST_WEIGHT;
        sh_lp_sel = 1'b0; sh_use_filt = 1'b1; sh_focal = RST_FOCAL;
        sh_max_dist = RST_MAX_DIST;
        vsum_x = 0; vsum_y = 0; lp_x = 0; lp_y = 0; psum_x = 0; psum_y = 0;
        nvalid = 0; phase = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero frames out of reset: nothing valid, distance zeroed
        none_r = '0;
        f = '0;
        row = '{f, 1'b0, none_r}; rows.push_back(row);
        row = '{f, 1'b1, none_r}; rows.push_back(row);
        // Extremes of every field, both signs
        f = '{20'hFFFFF, 16'hFFFF, 16'd5000, 20'sh7FFFF, -20'sh80000, 8'hFF,
              16'sh7FFF, -16'sh8000};
        row = '{f, 1'b0, none_r}; rows.push_back(row);
        f = '{20'd1, 16'd0, 16'd1, -20'sh80000, 20'sh7FFFF, 8'd1, -16'sh8000, 16'sh7FFF};
        row = '{f, 1'b0, none_r}; rows.push_back(row);
        // Distance above the limit, zero quality, zero interval
        f = '{20'd0, 16'd1234, 16'd5001, 20'sd100, 20'sd100, 8'd7, 16'sd300, -16'sd300};
        row = '{f, 1'b0, none_r}; rows.push_back(row);
        f = '{20'd10000, 16'd99, 16'd1000, 20'sd0, 20'sd0, 8'd0, 16'sd256, 16'sd256};
        row = '{f, 1'b0, none_r}; rows.push_back(row);
        // Pixel sums near the ends of their 17-bit range over a report pair
        f = '{20'd20000, 16'd500, 16'd2000, 20'sd5, -20'sd5, 8'd200, 16'sh7FFF, -16'sh8000};
        row = '{f, 1'b0, none_r}; rows.push_back(row);
        row = '{f, 1'b0, none_r}; rows.push_back(row);
        f = '{20'd33333, 16'd800, 16'd4999, 20'sd2000, -20'sd3000, 8'd90, 16'sd1000, 16'sd500};
        row = '{f, 1'b0, none_r}; rows.push_back(row);
        row = '{f, 1'b0, none_r}; rows.push_back(row);
        foreach (rows[k]) send_frame(rows[k].f, rows[k].known, rows[k].r);
        drain();

        // Register settings: extremes, including zero focal length and zero max distance
        write_reg(CFG_GYRO_EN, 0);
        write_reg(CFG_GYRO_THR, 19'h7FFFF);
        write_reg(CFG_WEIGHT, 16'hFFFF);
        write_reg(CFG_LP_SEL, 1);
        write_reg(CFG_USE_FILT, 0);
        write_reg(CFG_FOCAL, 0);
        write_reg(CFG_MAX_DIST, 16'hFFFF);
        write_reg(3'd7, 19'h12345);
        foreach (rows[k]) send_frame(rows[k].f, 1'b0, none_r);
        drain();

        write_reg(CFG_FOCAL, 16'hFFFF);
        write_reg(CFG_MAX_DIST, 0);
        write_reg(CFG_WEIGHT, 0);
        foreach (rows[k]) send_frame(rows[k].f, 1'b0, none_r);
        drain();

        // Random phases, each with a fresh random setting
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_GYRO_EN, $urandom_range(0, 1));
            write_reg(CFG_GYRO_THR, ($urandom_range(0, 1)) ? $urandom_range(0, 5000)
                                                           : 19'($urandom()));
            write_reg(CFG_WEIGHT, 16'($urandom()));
            write_reg(CFG_LP_SEL, $urandom_range(0, 1));
            write_reg(CFG_USE_FILT, $urandom_range(0, 1));
            write_reg(CFG_FOCAL, ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                             : $urandom_range(4000, 12000));
            write_reg(CFG_MAX_DIST, ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                                : $urandom_range(1000, 10000));
            if (ph == 3) hold_off = 1'b1;
            for (i = 0; i < 100; i++) send_frame(random_frame(), 1'b0, none_r);
            drain();
        end

        $display("Covered %0d frames and %0d reports across 11 register settings,",
                 n_frames, n_reports);
        $display("including zero focal length, zero max distance and a long output stall.");
        if (errors == 0) begin
            $display("PASS flow_to_velocity_estimator_top");
        end else begin
            $display("FAIL flow_to_velocity_estimator_top");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL flow_to_velocity_estimator_top");
        $finish;
    end

endmodule
`default_nettype wire

/* flow_to_velocity_estimator_top.f */
+incdir+sv
sv/fve_pkg.sv
sv/fve_div.sv
sv/fve_datapath.sv
sv/fve_ctrl.sv
sv/flow_to_velocity_estimator_top.sv
sv/fve_checker.sv
tb/flow_to_velocity_estimator_top_tb.sv
